[src/svwd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// Package for the stopped vehicle window detector: item types, register map,
// zone codes, sequencer states and window sizing. Depends on nothing.
package svwd_pkg;

	localparam int HISTORY_DEPTH = 5;
	localparam int SLOT_W        = $clog2(HISTORY_DEPTH);
	localparam int ECHO_W        = 10;
	localparam int HUM_W         = 7;
	localparam int PADDR_W       = 4;
	localparam int PDATA_W       = 32;

	localparam logic [ECHO_W-1:0] NEAR_RESET = ECHO_W'(117);
	localparam logic [ECHO_W-1:0] FAR_RESET  = ECHO_W'(291);
	localparam logic [ECHO_W-1:0] SPAN_RESET = ECHO_W'(58);
	localparam logic [HUM_W-1:0]  FOG_RESET  = HUM_W'(75);

	typedef enum logic [1:0] {
		REG_NEAR = 2'd0,
		REG_FAR  = 2'd1,
		REG_SPAN = 2'd2,
		REG_FOG  = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		ZS_NO_SIGNAL  = 2'd0,
		ZS_NO_VEHICLE = 2'd1,
		ZS_MOVING     = 2'd2,
		ZS_STOPPED    = 2'd3
	} zone_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [ECHO_W-1:0] echo_time_us;
		logic [HUM_W-1:0]  humidity_pct;
		logic              humidity_ok;
	} sample_t;

	typedef struct packed {
		logic       green_lamp;
		logic       amber_lamp;
		logic       red_lamp;
		logic [1:0] zone_status;
	} result_t;

	typedef struct packed {
		logic clear;
		logic push;
		logic scan;
	} win_ctrl_t;

	typedef struct packed {
		logic full;
		logic last_slot;
		logic done;
		logic still;
	} win_stat_t;

endpackage
`default_nettype wire

[src/svwd_window.sv]
`timescale 1ns / 1ps
`default_nettype none
// Echo history ring with a shared min/max unit that scans one entry a cycle.
// Depends on svwd_pkg.
module svwd_window (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire svwd_pkg::win_ctrl_t       ctrl,
	input  wire logic [svwd_pkg::ECHO_W-1:0] push_echo,
	input  wire logic [svwd_pkg::ECHO_W-1:0] still_span,
	output svwd_pkg::win_stat_t            stat
);
	import svwd_pkg::*;

	localparam logic [SLOT_W-1:0] LAST = SLOT_W'(HISTORY_DEPTH - 1);

	logic [ECHO_W-1:0] ring_q [HISTORY_DEPTH];
	logic [SLOT_W-1:0] slot_q;
	logic              full_q;
	logic [SLOT_W-1:0] idx_q;
	logic              busy_q;
	logic              done_q;
	logic [ECHO_W-1:0] lo_q;
	logic [ECHO_W-1:0] hi_q;
	logic [ECHO_W-1:0] entry;
	logic [ECHO_W-1:0] span;

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			ring_q[slot_q] <= push_echo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			full_q <= 1'b0;
		end else if (ctrl.clear) begin
			slot_q <= '0;
			full_q <= 1'b0;
		end else if (ctrl.push) begin
			if (slot_q == LAST) begin
				slot_q <= '0;
				full_q <= 1'b1;
			end else begin
				slot_q <= slot_q + SLOT_W'(1);
			end
		end
	end

	assign entry = ring_q[idx_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (idx_q == LAST);
			if (ctrl.scan) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (busy_q) begin
				if (idx_q == LAST) begin
					busy_q <= 1'b0;
					idx_q  <= '0;
				end else begin
					idx_q <= idx_q + SLOT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			if (idx_q == '0) begin
				lo_q <= entry;
				hi_q <= entry;
			end else begin
				if (entry < lo_q) begin
					lo_q <= entry;
				end
				if (entry > hi_q) begin
					hi_q <= entry;
				end
			end
		end
	end

	assign span           = hi_q - lo_q;
	assign stat.full      = full_q;
	assign stat.last_slot = (slot_q == LAST);
	assign stat.done      = done_q;
	assign stat.still     = (span <= still_span);

endmodule
`default_nettype wire

[src/stopped_vehicle_window_detector.sv]
`timescale 1ns / 1ps
`default_nettype none
// Stopped vehicle window detector top level: configuration registers, sequencer
// and result register. Depends on svwd_pkg and svwd_window.
//
// Each sample item yields one result item. A timeout, an echo outside the zone, or
// an in-zone echo while the five-entry history is still filling goes from the idle
// state straight to the output state, which loads the result register. Once the
// history is full, an in-zone echo starts a min/max scan that reads one stored entry
// per cycle through a single compare unit; the sequencer waits in the scan state
// until the scan is done and then moves to the output state. The sample channel is
// stalled while an item is being worked on, so the next sample is taken only back in
// the idle state. A result that cannot yet replace a stalled one holds the sequencer. A
// finished result waits in the output register, and the next sample is taken meanwhile.
module stopped_vehicle_window_detector (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [svwd_pkg::PADDR_W-1:0] paddr,
	input  wire logic [svwd_pkg::PDATA_W-1:0] pwdata,
	output logic      [svwd_pkg::PDATA_W-1:0] prdata,
	output logic                             pready,
	input  wire logic                        sample_valid,
	output logic                             sample_stall,
	input  wire svwd_pkg::sample_t           sample,
	output logic                             result_valid,
	input  wire logic                        result_stall,
	output svwd_pkg::result_t                result
);
	import svwd_pkg::*;

	logic [ECHO_W-1:0] near_q;
	logic [ECHO_W-1:0] far_q;
	logic [ECHO_W-1:0] span_q;
	logic [HUM_W-1:0]  fog_q;
	reg_idx_t          reg_idx;
	logic              cfg_write;

	state_t    state_q;
	state_t    state_next;
	win_ctrl_t win_ctrl;
	win_stat_t win_stat;

	logic    accept;
	logic    timeout;
	logic    in_zone;
	logic    full_after;
	logic    out_free;
	logic    green_q;
	logic    amber_q;
	logic    red_q;
	zone_t   status_q;
	logic    result_valid_q;
	result_t result_q;

	assign pready    = 1'b1;
	assign reg_idx   = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_q <= NEAR_RESET;
			far_q  <= FAR_RESET;
			span_q <= SPAN_RESET;
			fog_q  <= FOG_RESET;
		end else if (cfg_write) begin
			case (reg_idx)
				REG_NEAR: near_q <= pwdata[ECHO_W-1:0];
				REG_FAR:  far_q  <= pwdata[ECHO_W-1:0];
				REG_SPAN: span_q <= pwdata[ECHO_W-1:0];
				REG_FOG:  fog_q  <= pwdata[HUM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_NEAR: prdata = PDATA_W'(near_q);
			REG_FAR:  prdata = PDATA_W'(far_q);
			REG_SPAN: prdata = PDATA_W'(span_q);
			REG_FOG:  prdata = PDATA_W'(fog_q);
			default:  prdata = '0;
		endcase
	end

	assign accept     = sample_valid && !sample_stall;
	assign timeout    = (sample.echo_time_us == '0);
	assign in_zone    = !timeout && (sample.echo_time_us >= near_q)
	                    && (sample.echo_time_us <= far_q);
	assign full_after = win_stat.full || win_stat.last_slot;
	assign out_free   = !result_valid_q || !result_stall;

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_next = (in_zone && full_after) ? ST_SCAN : ST_OUT;
				end
			end
			ST_SCAN: begin
				if (win_stat.done) begin
					state_next = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		sample_stall   = (state_q != ST_IDLE);
		win_ctrl.clear = accept && !timeout && !in_zone;
		win_ctrl.push  = accept && in_zone;
		win_ctrl.scan  = accept && in_zone && full_after;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			green_q  <= 1'b0;
			amber_q  <= 1'b0;
			red_q    <= 1'b0;
			status_q <= ZS_NO_SIGNAL;
		end else if (accept) begin
			green_q <= sample.humidity_ok && (sample.humidity_pct >= fog_q);
			if (timeout) begin
				status_q <= ZS_NO_SIGNAL;
			end else if (!in_zone) begin
				amber_q  <= 1'b0;
				red_q    <= 1'b0;
				status_q <= ZS_NO_VEHICLE;
			end else if (!full_after) begin
				amber_q  <= 1'b1;
				red_q    <= 1'b0;
				status_q <= ZS_MOVING;
			end
		end else if (state_q == ST_SCAN && win_stat.done) begin
			if (win_stat.still) begin
				amber_q  <= 1'b0;
				red_q    <= 1'b1;
				status_q <= ZS_STOPPED;
			end else begin
				amber_q  <= 1'b1;
				red_q    <= 1'b0;
				status_q <= ZS_MOVING;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			result_q.green_lamp  <= green_q;
			result_q.amber_lamp  <= amber_q;
			result_q.red_lamp    <= red_q;
			result_q.zone_status <= status_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	svwd_window u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (win_ctrl),
		.push_echo  (sample.echo_time_us),
		.still_span (span_q),
		.stat       (win_stat)
	);

endmodule
`default_nettype wire

[src/svwd_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// Port-level checker for the stopped vehicle window detector, bound to the top
// level. Depends on svwd_pkg.
module svwd_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        sample_valid,
	input wire logic                        sample_stall,
	input wire logic                        result_valid,
	input wire logic                        result_stall,
	input wire svwd_pkg::result_t           result
);
	import svwd_pkg::*;

	// A held result item stays offered until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result item dropped while stalled");

	// The block works on one item at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_stall |=> sample_stall)
		else $error("sample taken while an item is in progress");

	// The lamps agree with the zone code.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |->
			(result.zone_status == ZS_STOPPED && result.red_lamp && !result.amber_lamp) ||
			(result.zone_status == ZS_MOVING && result.amber_lamp && !result.red_lamp) ||
			(result.zone_status == ZS_NO_VEHICLE && !result.amber_lamp && !result.red_lamp) ||
			(result.zone_status == ZS_NO_SIGNAL && !(result.amber_lamp && result.red_lamp)))
		else $error("lamps disagree with zone status");

	// No result appears unless an item was taken earlier.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(sample_stall))
		else $error("result item without a sample in progress");

endmodule

bind stopped_vehicle_window_detector svwd_checker u_svwd_checker (.*);
`default_nettype wire
